// ===== rtl/core/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
package ple_pkg;

	localparam int LIST_CAPACITY = 16;
	localparam int WORD_W        = 32;
	localparam int ACTION_W      = 3;
	localparam int POS_W         = 5;
	localparam int STATUS_W      = 3;
	localparam int COUNT_W       = 5;
	// slot index width, enough for the largest supported capacity (64)
	localparam int IDX_MAX_W     = 6;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND   = 3'd0,
		ACT_PREPEND  = 3'd1,
		ACT_INSERT   = 3'd2,
		ACT_DEL_HEAD = 3'd3,
		ACT_DEL_TAIL = 3'd4,
		ACT_DEL_POS  = 3'd5,
		ACT_READ     = 3'd6
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_BADPOS = 3'd2,
		ST_FULL   = 3'd3,
		ST_ENTRY  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [IDX_MAX_W-1:0]   idx;
	} cell_ctl_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// One list slot: holds a word and takes it from the word bus or a neighbor.
module ple_cell #(
	parameter int INDEX = 0
) (
	input  logic                    clk,
	input  ple_pkg::cell_ctl_t      ctl,
	input  logic [ple_pkg::WORD_W-1:0] word,
	input  logic [ple_pkg::WORD_W-1:0] left,
	input  logic [ple_pkg::WORD_W-1:0] right,
	output logic [ple_pkg::WORD_W-1:0] data
);
	import ple_pkg::*;

	localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(INDEX);

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (MY_IDX == ctl.idx) begin
					data_q <= word;
				end else if (MY_IDX > ctl.idx) begin
					data_q <= left;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= ctl.idx) begin
					data_q <= right;
				end
			end
			// idx marks the tail slot; the head word wraps in there
			CELL_ROTATE: begin
				if (MY_IDX == ctl.idx) begin
					data_q <= word;
				end else if (MY_IDX < ctl.idx) begin
					data_q <= right;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Top level: command decode, occupancy, read-out sequencing and the slot chain.
// A mutation's status is registered and appears in the cycle after its request is taken;
// busy stays low, so a new request may follow every cycle.
// Read-out of n entries: busy is high while the sequencer steps through them, paced
// by the slot chain rotating one position per cycle. Empty read-out: a single ST_EMPTY status.
// Reset clears occupancy and control; slot contents are not reset. valid is a strobe.
module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::LIST_CAPACITY
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ple_pkg::ACTION_W-1:0]     action,
	input  logic signed [ple_pkg::WORD_W-1:0] value,
	input  logic [ple_pkg::POS_W-1:0]        position,
	output logic                             busy,
	output logic                             valid,
	output logic [ple_pkg::STATUS_W-1:0]     status,
	output logic signed [ple_pkg::WORD_W-1:0] entry_value,
	output logic [ple_pkg::COUNT_W-1:0]      entry_count,
	output logic                             last
);
	import ple_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam logic [CMP_W-1:0] CAP_W = CMP_W'(CAPACITY);

	typedef enum logic {S_IDLE, S_READ} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    rem_q;
	logic                valid_q;
	status_t             status_q;
	logic [WORD_W-1:0]   entry_value_q;
	logic [COUNT_W-1:0]  entry_count_q;
	logic                last_q;

	logic                accept;
	logic [CMP_W-1:0]    cnt_w;
	logic [CMP_W-1:0]    pos_w;
	logic                is_full;
	logic                is_empty;
	cell_ctl_t           ctl;
	status_t             st_n;
	logic [CNT_W-1:0]    cnt_n;
	logic                go_read;
	logic [WORD_W-1:0]   bcast_word;
	logic [WORD_W-1:0]   cell_data [CAPACITY];

	assign busy     = (state_q == S_READ);
	assign accept   = start && !busy;
	assign cnt_w    = CMP_W'(cnt_q);
	assign pos_w    = CMP_W'(position);
	assign is_full  = (cnt_w == CAP_W);
	assign is_empty = (cnt_q == '0);

	always_comb begin
		ctl.op  = CELL_HOLD;
		ctl.idx = '0;
		st_n    = ST_OK;
		cnt_n   = cnt_q;
		go_read = 1'b0;
		if (state_q == S_READ) begin
			ctl.op  = CELL_ROTATE;
			ctl.idx = IDX_MAX_W'(cnt_w - CMP_W'(1));
		end else if (accept) begin
			case (action)
				ACT_APPEND, ACT_PREPEND: begin
					if (is_full) begin
						st_n = ST_FULL;
					end else begin
						ctl.op  = CELL_INSERT;
						ctl.idx = (action == ACT_APPEND) ? IDX_MAX_W'(cnt_w) : '0;
						cnt_n   = CNT_W'(cnt_w + CMP_W'(1));
					end
				end
				ACT_INSERT: begin
					if (is_full) begin
						st_n = ST_FULL;
					end else if (is_empty && pos_w != CMP_W'(1)) begin
						st_n = ST_EMPTY;
					end else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
						st_n = ST_BADPOS;
					end else begin
						ctl.op  = CELL_INSERT;
						ctl.idx = IDX_MAX_W'(pos_w - CMP_W'(1));
						cnt_n   = CNT_W'(cnt_w + CMP_W'(1));
					end
				end
				ACT_DEL_HEAD: begin
					if (is_empty) begin
						st_n = ST_EMPTY;
					end else begin
						ctl.op = CELL_REMOVE;
						cnt_n  = CNT_W'(cnt_w - CMP_W'(1));
					end
				end
				ACT_DEL_TAIL: begin
					if (is_empty) begin
						st_n = ST_EMPTY;
					end else begin
						cnt_n = CNT_W'(cnt_w - CMP_W'(1));
					end
				end
				ACT_DEL_POS: begin
					if (is_empty) begin
						st_n = ST_EMPTY;
					end else if (pos_w == '0 || pos_w > cnt_w) begin
						st_n = ST_BADPOS;
					end else begin
						ctl.op  = CELL_REMOVE;
						ctl.idx = IDX_MAX_W'(pos_w - CMP_W'(1));
						cnt_n   = CNT_W'(cnt_w - CMP_W'(1));
					end
				end
				ACT_READ: begin
					if (is_empty) begin
						st_n = ST_EMPTY;
					end else begin
						go_read = 1'b1;
					end
				end
				default: begin
					st_n = ST_OK;
				end
			endcase
		end
	end

	// during read-out the head word wraps around to the tail
	assign bcast_word = (state_q == S_READ) ? cell_data[0] : value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		ple_cell #(
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.word  (bcast_word),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			rem_q         <= '0;
			valid_q       <= 1'b0;
			status_q      <= ST_OK;
			entry_value_q <= '0;
			entry_count_q <= '0;
			last_q        <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_n;
						if (go_read) begin
							state_q <= S_READ;
							rem_q   <= cnt_q;
						end else begin
							valid_q       <= 1'b1;
							status_q      <= st_n;
							entry_value_q <= '0;
							entry_count_q <= COUNT_W'(cnt_n);
							last_q        <= 1'b1;
						end
					end
				end
				S_READ: begin
					valid_q       <= 1'b1;
					status_q      <= ST_ENTRY;
					entry_value_q <= cell_data[0];
					entry_count_q <= COUNT_W'(cnt_q);
					last_q        <= (rem_q == CNT_W'(1));
					rem_q         <= rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign valid       = valid_q;
	assign status      = status_q;
	assign entry_value = entry_value_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (cnt_q != '0 && rem_q != '0))
		else $error("read-out running on an empty list");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cnt_q) <= CAP_W)
		else $error("occupancy above capacity");

	a_read_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_READ && cnt_q != '0) |=> (busy && !valid))
		else $error("read-out request did not start the sequencer");

	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status == ST_ENTRY && last) |-> !busy)
		else $error("final read-out result while still busy");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status != ST_ENTRY) |-> (last && entry_value == '0))
		else $error("status result not a single final result");

endmodule
